### hw/rtl/ccla_pkg.sv
// ----------------------------------------------------------------------------
// ccla_pkg: shared types and constants of the charge current lease allocator
// Holds the sizes, the item, result and lease payloads, the operation codes,
// the result kinds and the register indexes.
package ccla_pkg;

  // Sizing of the charger table and the lease store.
  localparam int CHARGERS = 8;
  localparam int LPC      = 4;
  localparam int SLOTS    = CHARGERS * LPC;
  localparam int CW       = (CHARGERS > 1) ? $clog2(CHARGERS) : 1;
  localparam int LKW      = (LPC > 1) ? $clog2(LPC) : 1;
  localparam int LCW      = $clog2(LPC + 1);
  localparam int AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TW       = 16 + $clog2(CHARGERS + 1);

  // Fixed field width and the millisecond scale.
  localparam int ID_W     = 3;
  localparam int MS_PER_S = 1000;

  // Item operation codes.
  localparam logic [1:0] FUNC_SET = 2'd0;
  localparam logic [1:0] FUNC_ASK = 2'd1;
  localparam logic [1:0] FUNC_ACT = 2'd2;

  // Result kinds.
  localparam logic KIND_GRANT = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MAX  = 2'd0;
  localparam logic [1:0] REG_DUR  = 2'd1;
  localparam logic [1:0] REG_REXP = 2'd2;
  localparam logic [1:0] REG_THR  = 2'd3;

  typedef struct packed {
    logic [1:0]      func;
    logic [ID_W-1:0] charger_id;
    logic [31:0]     now_ms;
    logic [15:0]     request_tenths;
    logic [15:0]     cur_allocated_tenths;
    logic [31:0]     cur_expiry_ms;
    logic [31:0]     cur_created_index;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] lease_idx;
    logic [15:0] allocated_tenths;
    logic [31:0] expiry_ms;
    logic [31:0] finish_idx;
  } result_t;

  typedef struct packed {
    logic [31:0] created;
    logic [15:0] amount;
    logic [31:0] expiry;
    logic        done;
    logic [31:0] done_idx;
  } lease_t;

endpackage

### hw/rtl/ccla_item_if.sv
// ----------------------------------------------------------------------------
// ccla_item_if: input item channel
// Valid/ready channel that carries one allocator item per transfer.
// ----------------------------------------------------------------------------
interface ccla_item_if;
  logic            valid;
  logic            ready;
  ccla_pkg::item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/ccla_result_if.sv
// ----------------------------------------------------------------------------
// ccla_result_if: result channel
// Valid/ready channel that carries one allocator result per transfer.
// ----------------------------------------------------------------------------
interface ccla_result_if;
  logic              valid;
  logic              ready;
  ccla_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/charge_current_lease_allocator.sv
// ----------------------------------------------------------------------------
// charge_current_lease_allocator: timed current leases for a charger site
// A set-request item finishes in its accept cycle. An activate item makes
// four reads of the charger's lease entries from the lease memory, an
// update step and four write-backs. An ask item sums the fresh requests,
// one charger per cycle, prunes the leases of each other charger through
// the lease memory, runs the bit-serial divider, and makes one more lease
// memory pass when a lease is granted. The lease memory walk and the
// divider take most of an ask item's time. The next item is taken once the
// present one is finished; a finished result waits in the output register,
// and a new result waits in the finishing state until that register is
// empty.
// ----------------------------------------------------------------------------
module charge_current_lease_allocator (
  input  logic         clk_i,
  input  logic         rst_ni,
  ccla_item_if.sink    item_i,
  ccla_result_if.source result_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ccla_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_REQ  = 4'd1;
  localparam logic [3:0] ST_LSEL = 4'd2;
  localparam logic [3:0] ST_LRD  = 4'd3;
  localparam logic [3:0] ST_MOD  = 4'd4;
  localparam logic [3:0] ST_WR   = 4'd5;
  localparam logic [3:0] ST_DIV  = 4'd6;
  localparam logic [3:0] ST_DEC  = 4'd7;
  localparam logic [3:0] ST_FIN  = 4'd8;

  localparam logic [1:0] MD_PRUNE = 2'd0;
  localparam logic [1:0] MD_INS   = 2'd1;
  localparam logic [1:0] MD_ACT   = 2'd2;

  // Configuration registers.
  logic [15:0] cfg_max_q;
  logic [11:0] cfg_dur_q, cfg_rexp_q, cfg_thr_q;

  // Request table and lease valid bits.
  logic        rq_pres_q [CHARGERS];
  logic [15:0] rq_amt_q  [CHARGERS];
  logic [31:0] rq_time_q [CHARGERS];
  logic [SLOTS-1:0] lp_q;

  // Lease memory.
  lease_t          mem [SLOTS];
  lease_t          rd_q;
  logic [AW-1:0]   raddr, waddr;
  logic            we;
  lease_t          wdata;

  // Sequencer state.
  logic [3:0]      st_q;
  logic [1:0]      mode_q;
  item_t           it_q;
  logic [CW:0]     c_q;
  logic [LCW-1:0]  k_q;
  logic [TW-1:0]   total_q, leased_q;
  logic            fresh_id_q, zero_q;
  logic [15:0]     req_id_q, share_q;
  logic [31:0]     idx_q, cnt_q;
  lease_t          ent_q [LPC];
  logic [LPC-1:0]  bp_q;
  logic [TW-1:0]   rem_q;
  logic [31:0]     quo_q;
  logic [4:0]      dcnt_q;
  result_t         res_q;
  logic            res_valid_q;

  logic            acc, id_ok, cfg_we;
  logic [CW-1:0]   c_idx, id_idx;
  logic [AW-1:0]   base;
  logic [21:0]     rexp1000, thr1000;
  logic [31:0]     dur1000, new_exp, rq_d;
  logic            fresh_c, fid;
  lease_t          nb [LPC];
  logic [LPC-1:0]  np;
  logic [15:0]     nmax;
  logic [TW:0]     dv_t;
  logic [TW+1:0]   cap;
  logic [15:0]     qmin, share;
  logic [31:0]     rem_ms;
  logic [32:0]     rem_s;
  logic            refresh;

  // Handshakes and decoded indexes.
  assign item_i.ready    = (st_q == ST_IDLE);
  assign acc             = item_i.valid && item_i.ready;
  assign id_ok           = int'(item_i.payload.charger_id) < CHARGERS;
  assign result_o.valid  = res_valid_q;
  assign result_o.payload = res_q;
  assign pready          = 1'b1;
  assign cfg_we          = psel && penable && pwrite;
  assign c_idx           = c_q[CW-1:0];
  assign id_idx          = CW'(it_q.charger_id);
  assign base            = AW'(int'(c_idx) * LPC);

  // Scaled times.
  assign rexp1000 = 22'(cfg_rexp_q) * 22'(MS_PER_S);
  assign thr1000  = 22'(cfg_thr_q) * 22'(MS_PER_S);
  assign dur1000  = 32'(cfg_dur_q) * 32'(MS_PER_S);
  assign new_exp  = it_q.now_ms + dur1000;

  // Freshness of the request under the walk counter.
  assign rq_d    = it_q.now_ms - rq_time_q[c_idx];
  assign fresh_c = rq_pres_q[c_idx] &&
                   ($signed({rq_d[31], rq_d}) < $signed({11'b0, rexp1000}));
  assign fid     = (c_idx == id_idx) ? fresh_c : fresh_id_q;

  // Configuration read.
  always_comb begin
    case (paddr[3:2])
      REG_MAX:  prdata = {16'b0, cfg_max_q};
      REG_DUR:  prdata = {20'b0, cfg_dur_q};
      REG_REXP: prdata = {20'b0, cfg_rexp_q};
      REG_THR:  prdata = {20'b0, cfg_thr_q};
      default:  prdata = '0;
    endcase
  end

  // Lease memory ports.
  assign raddr = base + AW'(k_q);
  assign waddr = base + AW'(k_q);
  assign we    = (st_q == ST_WR);
  assign wdata = ent_q[k_q[LKW-1:0]];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // Update of one charger's lease list: prune, activate or insert, then pack.
  always_comb begin
    lease_t         e [LPC];
    logic [LPC-1:0] keep;
    logic           found;
    logic [LCW-1:0] n;
    logic [31:0]    df;
    found = 1'b0;
    n     = '0;
    nmax  = '0;
    df    = '0;
    for (int j = 0; j < LPC; j++) begin
      e[j]    = ent_q[j];
      nb[j]   = ent_q[j];
      np[j]   = 1'b0;
      keep[j] = bp_q[j];
    end
    case (mode_q)
      MD_PRUNE: begin
        for (int j = 0; j < LPC; j++) begin
          df      = it_q.now_ms - e[j].expiry;
          keep[j] = bp_q[j] && !($signed(df) > 0);
        end
      end
      MD_ACT: begin
        for (int j = 0; j < LPC; j++) begin
          if (bp_q[j] && !found && e[j].created == it_q.cur_created_index) begin
            e[j].done     = 1'b1;
            e[j].done_idx = idx_q;
            found         = 1'b1;
          end
        end
        for (int j = 0; j < LPC; j++) begin
          df      = it_q.cur_created_index - e[j].done_idx;
          keep[j] = bp_q[j] && !(e[j].done && ($signed(df) > 0));
        end
      end
      MD_INS: begin
        if (&bp_q) begin
          keep[0] = 1'b0;
        end
      end
      default: ;
    endcase
    for (int j = 0; j < LPC; j++) begin
      if (keep[j]) begin
        nb[n[LKW-1:0]] = e[j];
        np[n[LKW-1:0]] = 1'b1;
        if (e[j].amount > nmax) begin
          nmax = e[j].amount;
        end
        n = n + 1'b1;
      end
    end
    if (mode_q == MD_INS) begin
      nb[n[LKW-1:0]] = '{created: idx_q, amount: share_q, expiry: new_exp,
                         done: 1'b0, done_idx: 32'd0};
      np[n[LKW-1:0]] = 1'b1;
    end
  end

  // One restoring division step.
  assign dv_t = {rem_q, quo_q[31]};

  // Share limits and the refresh decision.
  assign qmin  = (quo_q < 32'(req_id_q)) ? quo_q[15:0] : req_id_q;
  assign cap   = (TW+2)'(cfg_max_q) - (TW+2)'(leased_q);
  assign share = zero_q ? 16'd0 :
                 cap[TW+1] ? 16'd0 :
                 (cap < (TW+2)'(qmin)) ? cap[15:0] : qmin;
  assign rem_ms  = it_q.cur_expiry_ms - it_q.now_ms;
  assign rem_s   = {rem_ms[31], rem_ms};
  assign refresh = (share != it_q.cur_allocated_tenths) ||
                   ($signed(rem_s) <= -33'sd1000) ||
                   (rem_s[32] && (cfg_thr_q != '0)) ||
                   (!rem_s[32] && ($signed(rem_s) < $signed({11'b0, thr1000})));

  // Sequencer and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_max_q   <= 16'd320;
      cfg_dur_q   <= 12'd30;
      cfg_rexp_q  <= 12'd60;
      cfg_thr_q   <= 12'd10;
      for (int i = 0; i < CHARGERS; i++) begin
        rq_pres_q[i] <= 1'b0;
        rq_amt_q[i]  <= '0;
        rq_time_q[i] <= '0;
      end
      lp_q        <= '0;
      st_q        <= ST_IDLE;
      mode_q      <= MD_PRUNE;
      it_q        <= '0;
      c_q         <= '0;
      k_q         <= '0;
      total_q     <= '0;
      leased_q    <= '0;
      fresh_id_q  <= 1'b0;
      zero_q      <= 1'b0;
      req_id_q    <= '0;
      share_q     <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      for (int j = 0; j < LPC; j++) begin
        ent_q[j] <= '0;
      end
      bp_q        <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      dcnt_q      <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        case (paddr[3:2])
          REG_MAX:  cfg_max_q  <= pwdata[15:0];
          REG_DUR:  cfg_dur_q  <= pwdata[11:0];
          REG_REXP: cfg_rexp_q <= pwdata[11:0];
          REG_THR:  cfg_thr_q  <= pwdata[11:0];
          default: ;
        endcase
      end

      // Result transfer.
      if (res_valid_q && result_o.ready) begin
        res_valid_q <= 1'b0;
      end

      case (st_q)
        ST_IDLE: begin
          if (acc && id_ok) begin
            it_q <= item_i.payload;
            case (item_i.payload.func)
              FUNC_SET: begin
                rq_pres_q[CW'(item_i.payload.charger_id)] <= 1'b1;
                rq_amt_q[CW'(item_i.payload.charger_id)]  <=
                  item_i.payload.request_tenths;
                rq_time_q[CW'(item_i.payload.charger_id)] <= item_i.payload.now_ms;
              end
              FUNC_ASK: begin
                idx_q      <= cnt_q;
                cnt_q      <= cnt_q + 32'd1;
                c_q        <= '0;
                total_q    <= '0;
                leased_q   <= '0;
                fresh_id_q <= 1'b0;
                st_q       <= ST_REQ;
              end
              FUNC_ACT: begin
                idx_q  <= cnt_q;
                cnt_q  <= cnt_q + 32'd1;
                c_q    <= (CW+1)'(item_i.payload.charger_id);
                mode_q <= MD_ACT;
                k_q    <= '0;
                st_q   <= ST_LRD;
              end
              default: ;
            endcase
          end
        end

        // Sum of fresh requests, one charger a cycle.
        ST_REQ: begin
          if (fresh_c) begin
            total_q <= total_q + TW'(rq_amt_q[c_idx]);
          end
          if (c_idx == id_idx) begin
            fresh_id_q <= fresh_c;
            req_id_q   <= rq_amt_q[c_idx];
          end
          if (int'(c_q) == CHARGERS - 1) begin
            if (!fid) begin
              zero_q <= 1'b1;
              st_q   <= ST_DEC;
            end else begin
              c_q  <= '0;
              st_q <= ST_LSEL;
            end
          end else begin
            c_q <= c_q + 1'b1;
          end
        end

        // Next other charger to prune, or the division.
        ST_LSEL: begin
          if (int'(c_q) == CHARGERS) begin
            if (total_q == '0) begin
              zero_q <= 1'b1;
              st_q   <= ST_DEC;
            end else begin
              zero_q <= 1'b0;
              quo_q  <= 32'(req_id_q) * 32'(cfg_max_q);
              rem_q  <= '0;
              dcnt_q <= '0;
              st_q   <= ST_DIV;
            end
          end else if (c_idx == id_idx) begin
            c_q <= c_q + 1'b1;
          end else begin
            mode_q <= MD_PRUNE;
            k_q    <= '0;
            st_q   <= ST_LRD;
          end
        end

        // Read the charger's entries; data arrives in the cycle after its address.
        ST_LRD: begin
          if (k_q != '0) begin
            ent_q[LKW'(k_q - 1'b1)] <= rd_q;
          end
          if (int'(k_q) == LPC) begin
            for (int j = 0; j < LPC; j++) begin
              bp_q[j] <= lp_q[int'(base) + j];
            end
            st_q <= ST_MOD;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end

        ST_MOD: begin
          for (int j = 0; j < LPC; j++) begin
            ent_q[j]              <= nb[j];
            lp_q[int'(base) + j]  <= np[j];
          end
          if (mode_q == MD_PRUNE) begin
            leased_q <= leased_q + TW'(nmax);
          end
          k_q  <= '0;
          st_q <= ST_WR;
        end

        // Write the packed list back.
        ST_WR: begin
          if (int'(k_q) == LPC - 1) begin
            if (mode_q == MD_PRUNE) begin
              c_q  <= c_q + 1'b1;
              st_q <= ST_LSEL;
            end else begin
              st_q <= ST_FIN;
            end
          end else begin
            k_q <= k_q + 1'b1;
          end
        end

        // Bit-serial quotient of request times budget over total.
        ST_DIV: begin
          if (dv_t >= {1'b0, total_q}) begin
            rem_q <= TW'(dv_t - {1'b0, total_q});
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= dv_t[TW-1:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 5'd31) begin
            st_q <= ST_DEC;
          end
        end

        ST_DEC: begin
          if (refresh) begin
            share_q <= share;
            c_q     <= (CW+1)'(it_q.charger_id);
            mode_q  <= MD_INS;
            k_q     <= '0;
            st_q    <= ST_LRD;
          end else begin
            st_q <= ST_IDLE;
          end
        end

        // The new result waits until the output register is empty.
        ST_FIN: begin
          if (!res_valid_q) begin
            if (mode_q == MD_INS) begin
              res_q <= '{kind: KIND_GRANT, lease_idx: idx_q,
                         allocated_tenths: share_q, expiry_ms: new_exp,
                         finish_idx: 32'd0};
            end else begin
              res_q <= '{kind: KIND_DONE, lease_idx: it_q.cur_created_index,
                         allocated_tenths: 16'd0, expiry_ms: 32'd0,
                         finish_idx: idx_q};
            end
            res_valid_q <= 1'b1;
            st_q        <= ST_IDLE;
          end
        end

        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // True when every charger's valid bits form a prefix.
  function automatic logic packed_ok(logic [SLOTS-1:0] p);
    logic ok;
    ok = 1'b1;
    for (int c = 0; c < CHARGERS; c++) begin
      for (int j = 1; j < LPC; j++) begin
        if (p[c*LPC + j] && !p[c*LPC + j - 1]) begin
          ok = 1'b0;
        end
      end
    end
    return ok;
  endfunction

  // A result appears only from the finishing state.
  a_res_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(st_q) == ST_FIN)
    else $error("result raised outside the finishing state");

  // Lease lists stay packed between items.
  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_IDLE |-> packed_ok(lp_q))
    else $error("lease list has a hole");

  // Each ask or activate takes exactly one index.
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && id_ok && (item_i.payload.func == FUNC_ASK ||
                      item_i.payload.func == FUNC_ACT))
    |=> cnt_q == $past(cnt_q) + 32'd1)
    else $error("index counter did not advance by one");

  // The divider never runs on a zero total.
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_DIV |-> total_q != '0)
    else $error("division by a zero total");

endmodule
